// ----- rtl/xpmpd_pkg.sv -----
package xpmpd_pkg;

    // palette geometry
    localparam int PALETTE_DEPTH  = 65536;
    localparam int IDX_W          = $clog2(PALETTE_DEPTH);
    localparam int MAX_CODE_CHARS = 2;

    // pixel code character range
    localparam logic [7:0] CHAR_LOW  = 8'h20;
    localparam logic [7:0] CHAR_HIGH = 8'hFE;
    localparam logic [7:0] CHAR_SPAN = 8'd223;

    localparam logic [31:0] OPAQUE_BLACK = 32'hFF00_0000;

    // input opcodes
    localparam logic [1:0] OP_DECODE     = 2'd0;
    localparam logic [1:0] OP_DEF_HEX    = 2'd1;
    localparam logic [1:0] OP_DEF_DIRECT = 2'd2;

    // command kinds between front and back
    localparam logic [1:0] CMD_NOP   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_BAD   = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] code_chars;
        logic [63:0] color_text;
        logic [3:0]  color_len;
        logic [31:0] direct_color;
    } t_in_word;

    typedef struct packed {
        logic [31:0] pixel_color;
        logic        status;
    } t_out_word;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] index;
        logic [31:0]      color;
    } t_cmd;

endpackage

// ----- rtl/xpm_palette_pixel_decoder.sv -----
// Palette-indexed pixel decoder.
// Input channel: a word (opcode, code characters, hex color text and length,
// direct color) is taken at a clock edge with push high and full low.
// Result channel: while empty is low the oldest result word (pixel_color,
// status) sits on o_result; it is taken at an edge with pop high.
// Configuration: i_cfg_we writes i_cfg_wdata into chars_per_pixel at once.
// Opcode 0 reads the palette entry of the pixel code, opcodes 1 and 2 write
// an entry from hex text or a direct color; a bad code character gives
// status 1 and leaves the palette alone.
// Path: a taken word waits in the command queue, the palette is read into a
// register, and the result is written into the result queue, where it shows.
// Throughput: one word per cycle unless clearing or a result stall holds it,
// set by the single palette port that does one read or one write per cycle.
// Reset: after reset a clearing pass writes zero to all 65536 palette entries,
// one per cycle; full stays high until the pass ends.
// Receiver stall: a four-word result queue and a two-word command queue
// absorb the stall, then full rises; nothing is dropped.
module xpm_palette_pixel_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_wdata,
    input  logic                 push,
    output logic                 full,
    input  xpmpd_pkg::t_in_word  i_item,
    input  logic                 pop,
    output logic                 empty,
    output xpmpd_pkg::t_out_word o_result
);
    import xpmpd_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic cq_full;
    logic cq_empty;
    logic cq_take;
    logic clearing;
    logic push_ok;

    assign full    = cq_full || clearing;
    assign push_ok = push && !full;

    // decode and classify
    xpmpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (i_item),
        .o_cmd       (front_cmd)
    );

    // decoupling queue
    xpmpd_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_ok),
        .i_cmd   (front_cmd),
        .o_full  (cq_full),
        .i_pop   (cq_take),
        .o_cmd   (queue_cmd),
        .o_empty (cq_empty)
    );

    // palette access and results
    xpmpd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_cmd_valid (!cq_empty),
        .o_cmd_take  (cq_take),
        .o_clearing  (clearing),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

// ----- rtl/xpmpd_front.sv -----
module xpmpd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_wdata,
    input  xpmpd_pkg::t_in_word i_item,
    output xpmpd_pkg::t_cmd    o_cmd
);
    import xpmpd_pkg::*;

    localparam logic [7:0] HEX_LC_BASE = 8'h61 - 8'd10;
    localparam logic [7:0] HEX_UC_BASE = 8'h41 - 8'd10;
    localparam logic [7:0] DIGIT_BASE  = 8'h30;

    logic [1:0]       r_cpp;
    logic [2:0]       char_cnt;
    logic [7:0]       c0;
    logic [7:0]       c1;
    logic             bad0;
    logic             bad1;
    logic             bad;
    logic [IDX_W-1:0] idx;

    // one hex character to its nibble, anything else is zero
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] v;
        v = 4'h0;
        if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - HEX_LC_BASE);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - HEX_UC_BASE);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - DIGIT_BASE);
        end
        return v;
    endfunction

    // hex string to color with the short-form nibble placement
    function automatic logic [31:0] hex_to_color(input logic [63:0] text,
                                                 input logic [3:0]  len);
        logic [3:0]  n [8];
        logic [31:0] v;
        for (int k = 0; k < 8; k++) begin
            n[k] = nibble_of(text[8*k +: 8]);
        end
        case (len)
            4'd3:    v = OPAQUE_BLACK | {8'h00, n[0], 4'h0, n[1], 4'h0, n[2], 4'h0};
            4'd4:    v = {n[0], 4'h0, n[1], 4'h0, n[2], 4'h0, n[3], 4'h0};
            4'd6:    v = {8'hFF, n[0], n[1], n[2], n[3], n[4], n[5]};
            4'd8:    v = {n[0], n[1], n[2], n[3], n[4], n[5], n[6], n[7]};
            default: v = OPAQUE_BLACK;
        endcase
        return v;
    endfunction

    // characters-per-pixel register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpp <= 2'd1;
        end else if (i_cfg_we) begin
            r_cpp <= i_cfg_wdata;
        end
    end

    // effective character count, clamped to 1..max
    always_comb begin
        char_cnt = {1'b0, r_cpp};
        if (r_cpp == 2'd0) begin
            char_cnt = 3'd1;
        end else if (int'(r_cpp) > MAX_CODE_CHARS) begin
            char_cnt = 3'(MAX_CODE_CHARS);
        end
    end

    // code characters to palette index
    assign c0   = i_item.code_chars[7:0];
    assign c1   = i_item.code_chars[15:8];
    assign bad0 = (c0 < CHAR_LOW) || (c0 > CHAR_HIGH);
    assign bad1 = (c1 < CHAR_LOW) || (c1 > CHAR_HIGH);
    // characters past the code word read as zero and are always bad
    assign bad  = bad0 || ((char_cnt >= 3'd2) && bad1) || (char_cnt > 3'd2);
    assign idx  = IDX_W'(c0 - CHAR_LOW)
                + ((char_cnt >= 3'd2) ? IDX_W'(16'(c1 - CHAR_LOW) * 16'(CHAR_SPAN))
                                      : IDX_W'(0));

    // classify the word into a back-end command
    always_comb begin
        o_cmd.index = idx;
        o_cmd.color = 32'h0;
        o_cmd.kind  = CMD_NOP;
        case (i_item.opcode)
            OP_DECODE: begin
                o_cmd.kind = bad ? CMD_BAD : CMD_READ;
            end
            OP_DEF_HEX: begin
                o_cmd.kind  = bad ? CMD_BAD : CMD_WRITE;
                o_cmd.color = hex_to_color(i_item.color_text, i_item.color_len);
            end
            OP_DEF_DIRECT: begin
                o_cmd.kind  = bad ? CMD_BAD : CMD_WRITE;
                o_cmd.color = i_item.direct_color;
            end
            default: begin
                o_cmd.kind = CMD_NOP;
            end
        endcase
    end

endmodule

// ----- rtl/xpmpd_cmd_queue.sv -----
module xpmpd_cmd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  xpmpd_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output xpmpd_pkg::t_cmd o_cmd,
    output logic            o_empty
);
    import xpmpd_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // two-entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

// ----- rtl/xpmpd_back.sv -----
module xpmpd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  xpmpd_pkg::t_cmd      i_cmd,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_take,
    output logic                 o_clearing,
    input  logic                 i_pop,
    output logic                 o_empty,
    output xpmpd_pkg::t_out_word o_result
);
    import xpmpd_pkg::*;

    localparam int OUT_DEPTH = 4;
    localparam int OPTR_W    = $clog2(OUT_DEPTH);

    logic [31:0]       r_mem [PALETTE_DEPTH];
    logic [31:0]       r_rd_data;
    logic              r_clearing;
    logic [IDX_W-1:0]  r_clr_addr;
    logic              r_pend;
    logic              r_pend_read;
    t_out_word         r_pend_word;
    t_out_word         r_ofifo [OUT_DEPTH];
    logic [OPTR_W-1:0] r_owp;
    logic [OPTR_W-1:0] r_orp;
    logic [OPTR_W:0]   r_ocnt;
    logic [OPTR_W:0]   n_ocnt;

    logic              issue;
    logic              mem_we;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_addr;
    logic [31:0]       mem_wdata;
    logic              opop;
    t_out_word         opush_word;

    // take a command when a result slot is sure to be free
    assign issue = !r_clearing && i_cmd_valid
                && ((r_ocnt + (OPTR_W+1)'(r_pend)) < (OPTR_W+1)'(OUT_DEPTH));
    assign o_cmd_take = issue;
    assign o_clearing = r_clearing;

    // single-port palette access, clear sweep has priority
    assign mem_we    = r_clearing || (issue && (i_cmd.kind == CMD_WRITE));
    assign mem_re    = issue && (i_cmd.kind == CMD_READ);
    assign mem_addr  = r_clearing ? r_clr_addr : i_cmd.index;
    assign mem_wdata = r_clearing ? 32'h0 : i_cmd.color;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == '1) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // one command in flight while the read data comes back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_pend_read             <= (i_cmd.kind == CMD_READ);
            r_pend_word.pixel_color <= (i_cmd.kind == CMD_WRITE) ? i_cmd.color : 32'h0;
            r_pend_word.status      <= (i_cmd.kind == CMD_BAD);
        end
    end

    // result queue
    assign opush_word = r_pend_read ? t_out_word'{pixel_color: r_rd_data, status: 1'b0}
                                    : r_pend_word;
    assign opop       = i_pop && !o_empty;
    assign o_empty    = (r_ocnt == '0);
    assign o_result   = r_ofifo[r_orp];
    assign n_ocnt     = r_ocnt + (OPTR_W+1)'(r_pend) - (OPTR_W+1)'(opop);

    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_ofifo[r_owp] <= opush_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (r_pend) begin
                r_owp <= r_owp + 1'b1;
            end
            if (opop) begin
                r_orp <= r_orp + 1'b1;
            end
            r_ocnt <= n_ocnt;
        end
    end

endmodule

// ----- rtl/xpmpd_checker.sv -----
module xpmpd_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 full,
    input logic                 pop,
    input logic                 empty,
    input xpmpd_pkg::t_out_word o_result
);
    import xpmpd_pkg::*;

    // full is high right after reset, as the palette clearing starts
    a_full_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> full)
        else $error("full low right after reset");

    // no results right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("empty low right after reset");

    // a bad code character never carries a colour
    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.status) |-> (o_result.pixel_color == 32'h0))
        else $error("error result with nonzero colour");

    // a waiting result holds until taken
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed");

endmodule

bind xpm_palette_pixel_decoder xpmpd_checker u_xpmpd_checker (.*);

// ----- bench/xpm_palette_pixel_decoder_tb.sv -----
`timescale 1ns / 1ps

module xpm_palette_pixel_decoder_tb;
    import xpmpd_pkg::*;

    // opcode with no operation behind it
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_WORDS = 360;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_wdata = 2'd0;
    logic       push = 1'b0;
    logic       full;
    t_in_word   i_item = '0;
    logic       pop = 1'b0;
    logic       empty;
    t_out_word  o_result;

    // shadow of the block's state
    logic [31:0] pal_model [PALETTE_DEPTH];
    logic [1:0]  cpp_model = 2'd1;

    t_in_word  send_q [$];
    t_out_word pixel_expect_q [$];
    int        words_left = 0;
    int        mismatches = 0;
    int        cycle_cnt = 0;
    int        in_gap = 0;
    int        out_hold = 0;
    bit        in_burst = 1'b0;
    bit        out_burst = 1'b0;
    t_out_word predicted;
    t_out_word want;

    xpm_palette_pixel_decoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .pop         (pop),
        .empty       (empty),
        .o_result    (o_result)
    );

    always #1 i_clk = ~i_clk;

    // value of hex character k, non-hex reads as zero
    function automatic logic [31:0] nib_at(logic [63:0] t, int k);
        logic [7:0] c;
        c = t[8*k +: 8];
        if (c >= "a" && c <= "f") return 32'(c - ("a" - 8'd10));
        if (c >= "A" && c <= "F") return 32'(c - ("A" - 8'd10));
        if (c >= "0" && c <= "9") return 32'(c - "0");
        return 32'd0;
    endfunction

    // color from hex text by string length
    function automatic logic [31:0] text_color(logic [63:0] t, logic [3:0] len);
        logic [31:0] v;
        int k;
        v = '0;
        case (len)
            4'd3: begin
                v = OPAQUE_BLACK | (nib_at(t, 0) << 20) | (nib_at(t, 1) << 12)
                    | (nib_at(t, 2) << 4);
            end
            4'd4: begin
                v = (nib_at(t, 0) << 28) | (nib_at(t, 1) << 20) | (nib_at(t, 2) << 12)
                    | (nib_at(t, 3) << 4);
            end
            4'd6: begin
                for (k = 0; k < 6; k++) v = (v << 4) | nib_at(t, k);
                v = OPAQUE_BLACK | v;
            end
            4'd8: begin
                for (k = 0; k < 8; k++) v = (v << 4) | nib_at(t, k);
            end
            default: begin
                v = OPAQUE_BLACK;
            end
        endcase
        return v;
    endfunction

    function automatic int chars_in_use();
        if (cpp_model == 2'd0) return 1;
        if (cpp_model > MAX_CODE_CHARS) return MAX_CODE_CHARS;
        return int'(cpp_model);
    endfunction

    // palette index of a pixel code, zero return on a bad character
    function automatic logic code_index(input logic [15:0] chars,
                                        output logic [IDX_W-1:0] idx);
        longint unsigned sum;
        longint unsigned weight;
        logic [7:0] c;
        int k;
        sum = 0;
        weight = 1;
        idx = '0;
        for (k = 0; k < chars_in_use(); k++) begin
            c = 8'(chars >> (8 * k));
            if (c < CHAR_LOW || c > CHAR_HIGH) return 1'b0;
            sum += longint'(c - CHAR_LOW) * weight;
            weight *= CHAR_SPAN;
        end
        idx = IDX_W'(sum % PALETTE_DEPTH);
        return 1'b1;
    endfunction

    // result of one word, palette shadow updated on a define
    task automatic decode_word(input t_in_word w, output t_out_word r);
        logic [IDX_W-1:0] idx;
        r = '0;
        if (w.opcode != OP_UNUSED) begin
            if (!code_index(w.code_chars, idx)) begin
                r.status = 1'b1;
            end else if (w.opcode == OP_DECODE) begin
                r.pixel_color = pal_model[idx];
            end else begin
                r.pixel_color = (w.opcode == OP_DEF_HEX) ?
                    text_color(w.color_text, w.color_len) : w.direct_color;
                pal_model[idx] = r.pixel_color;
            end
        end
    endtask

    function automatic t_in_word make_word(logic [1:0] op, logic [15:0] code, string text,
                                           logic [3:0] len, logic [31:0] direct);
        t_in_word w;
        int k;
        w = '0;
        w.opcode = op;
        w.code_chars = code;
        for (k = 0; k < text.len() && k < 8; k++) w.color_text[8*k +: 8] = text[k];
        w.color_len = len;
        w.direct_color = direct;
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        send_q.push_back(w);
        words_left++;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (words_left != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_cpp(input logic [1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        cpp_model = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly defines and decodes over a small code pool, some broken codes and noise
    task automatic queue_random(input int count);
        logic [15:0] pool [16];
        t_in_word w;
        int i;
        int r;
        int k;
        int c;
        for (i = 0; i < 16; i++) begin
            pool[i][7:0] = 8'($urandom_range(32, 254));
            pool[i][15:8] = (chars_in_use() == 2) ? 8'($urandom_range(32, 254))
                                                  : 8'($urandom_range(0, 255));
        end
        pool[0] = 16'h2020;
        pool[1] = 16'hFEFE;
        for (i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            w = '0;
            w.code_chars = pool[$urandom_range(0, 15)];
            for (k = 0; k < 8; k++) begin
                c = $urandom_range(0, 23);
                if (c < 10) w.color_text[8*k +: 8] = "0" + 8'(c);
                else if (c < 16) w.color_text[8*k +: 8] = "a" + 8'(c - 10);
                else if (c < 22) w.color_text[8*k +: 8] = "A" + 8'(c - 16);
                else w.color_text[8*k +: 8] = 8'($urandom_range(0, 255));
            end
            case ($urandom_range(0, 3))
                0: w.color_len = 4'd3;
                1: w.color_len = 4'd4;
                2: w.color_len = 4'd6;
                default: w.color_len = 4'd8;
            endcase
            if ($urandom_range(0, 7) == 0) w.color_len = 4'($urandom_range(0, 15));
            w.direct_color = $urandom;
            if (r < 40) begin
                w.opcode = OP_DECODE;
            end else if (r < 60) begin
                w.opcode = OP_DEF_HEX;
            end else if (r < 75) begin
                w.opcode = OP_DEF_DIRECT;
            end else if (r < 85) begin
                // one character of a pool code pushed out of range
                w.opcode = 2'($urandom_range(0, 2));
                k = $urandom_range(0, chars_in_use() - 1);
                w.code_chars[8*k +: 8] = $urandom_range(0, 1) ?
                    8'($urandom_range(0, 31)) : 8'hFF;
            end else begin
                w.opcode = 2'($urandom_range(0, 3));
                w.code_chars = 16'($urandom);
                w.color_text = {$urandom, $urandom};
                w.color_len = 4'($urandom_range(0, 15));
            end
            send_word(w);
        end
    endtask

    // input side: one word per handshake, random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                decode_word(i_item, predicted);
                pixel_expect_q.push_back(predicted);
                if ($urandom_range(0, 63) == 0) in_burst = !in_burst;
                in_gap = in_burst ? 0 : $urandom_range(0, 6);
            end
            if (!push || !full) begin
                if (in_gap > 0) begin
                    in_gap--;
                    push <= 1'b0;
                end else if (send_q.size() != 0) begin
                    i_item <= send_q.pop_front();
                    push <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // result side: compare each word with the oldest prediction, random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pixel_expect_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: pixel_color %h status %b",
                                 o_result.pixel_color, o_result.status);
                end else begin
                    want = pixel_expect_q.pop_front();
                    words_left--;
                    if (o_result.pixel_color !== want.pixel_color ||
                        o_result.status !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: pixel_color exp %h got %h, status exp %b got %b",
                                     want.pixel_color, o_result.pixel_color,
                                     want.status, o_result.status);
                    end
                end
                if ($urandom_range(0, 63) == 0) out_burst = !out_burst;
                out_hold = out_burst ? 0 : $urandom_range(0, 6);
            end else if (out_hold > 0) begin
                out_hold--;
            end
            pop <= (out_hold == 0);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("** xpm_palette_pixel_decoder: FAILED **");
            $finish;
        end
    end

    initial begin
        // palette shadow starts cleared like the block after reset
        foreach (pal_model[j]) pal_model[j] = 32'h0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words, one character per code
        send_word(make_word(OP_DECODE, 16'h0020, "", 4'd0, 32'd0));
        send_word(make_word(OP_DEF_HEX, 16'h0021, "f0a", 4'd3, 32'd0));
        send_word(make_word(OP_DECODE, 16'h0021, "", 4'd0, 32'd0));
        send_word(make_word(OP_DEF_HEX, 16'h0023, "AbC9", 4'd4, 32'd0));
        send_word(make_word(OP_DEF_HEX, 16'h0024, "12ab9F", 4'd6, 32'd0));
        send_word(make_word(OP_DEF_HEX, 16'h0025, "deadBEEF", 4'd8, 32'd0));
        send_word(make_word(OP_DEF_HEX, 16'h0026, "zq-G 9x/", 4'd8, 32'd0));
        send_word(make_word(OP_DEF_HEX, 16'h0027, "123", 4'd0, 32'd0));
        send_word(make_word(OP_DEF_HEX, 16'h0028, "12345", 4'd5, 32'd0));
        send_word(make_word(OP_DEF_HEX, 16'h0029, "ffffffff", 4'd15, 32'd0));
        send_word(make_word(OP_DECODE, 16'h0023, "", 4'd0, 32'd0));
        send_word(make_word(OP_DECODE, 16'h0025, "", 4'd0, 32'd0));
        send_word(make_word(OP_DEF_DIRECT, 16'h00FE, "", 4'd0, 32'hFFFF_FFFF));
        // upper character is ignored with one character per code
        send_word(make_word(OP_DECODE, 16'h41FE, "", 4'd0, 32'd0));
        send_word(make_word(OP_DEF_DIRECT, 16'h0020, "", 4'd0, 32'd0));
        send_word(make_word(OP_DECODE, 16'h0020, "", 4'd0, 32'd0));
        // bad characters on the decode and both define opcodes leave the palette alone
        send_word(make_word(OP_DECODE, 16'h001F, "", 4'd0, 32'd0));
        send_word(make_word(OP_DEF_HEX, 16'h00FF, "abc", 4'd3, 32'd0));
        send_word(make_word(OP_DEF_DIRECT, 16'h0000, "", 4'd0, 32'h1234_5678));
        send_word(make_word(OP_DECODE, 16'h0000, "", 4'd0, 32'd0));
        send_word(make_word(OP_UNUSED, 16'h0021, "fff", 4'd3, 32'hDEAD_BEEF));
        send_word(make_word(OP_DECODE, 16'h0021, "", 4'd0, 32'd0));
        send_word(make_word(OP_DECODE, 16'h0028, "", 4'd0, 32'd0));
        wait_idle();

        // random phases across code widths, out-of-range widths included
        set_cpp(2'd2);
        queue_random(PHASE_WORDS);
        wait_idle();
        set_cpp(2'd0);
        queue_random(PHASE_WORDS);
        wait_idle();
        set_cpp(2'd3);
        queue_random(PHASE_WORDS);
        wait_idle();
        set_cpp(2'd1);
        queue_random(PHASE_WORDS);
        wait_idle();
        set_cpp(2'd2);
        queue_random(PHASE_WORDS);
        wait_idle();

        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("** xpm_palette_pixel_decoder: PASSED **");
        end else begin
            $display("** xpm_palette_pixel_decoder: FAILED **");
        end
        $finish;
    end

endmodule
